FILE: src/julian_gregorian_day_advance_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Julian/Gregorian day advance block
// Checks are sampled on aclk and held off while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef JULIAN_GREGORIAN_DAY_ADVANCE_MACROS_SVH
`define JULIAN_GREGORIAN_DAY_ADVANCE_MACROS_SVH

// check a condition at every edge
`define JGDA_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// check a condition in the cycle after a trigger
`define JGDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/jgda_pkg.sv
// ----------------------------------------------------------------------------
// jgda_pkg
// Constants, types and month table shared by the day advance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jgda_pkg;

    localparam logic [29:0] YEAR_MAX        = 30'd1000000000;
    localparam logic [29:0] GAP_YEAR        = 30'd1582;
    localparam logic [29:0] PRE_GAP_LAST4   = 30'd1578;
    localparam logic [29:0] BC_START        = 30'd4713;
    localparam logic [29:0] BC_CHUNK_MIN    = 30'd5;
    localparam logic [29:0] AD_CHUNK_LAST   = YEAR_MAX - 30'd400;
    localparam logic [29:0] DAYS_4Y         = 30'd1461;
    localparam logic [29:0] DAYS_400Y       = 30'd146097;
    localparam logic [29:0] YEARS_400       = 30'd400;
    localparam logic [29:0] YEARS_4         = 30'd4;
    localparam logic [8:0]  DAYS_COMMON     = 9'd365;
    localparam logic [8:0]  DAYS_LEAP       = 9'd366;
    localparam logic [8:0]  CYCLE_LAST      = 9'd399;
    localparam logic [8:0]  CYCLE_LEN       = 9'd400;
    localparam logic [4:0]  GAP_SKIP_DAY    = 5'd5;
    localparam logic [4:0]  GAP_RESUME_DAY  = 5'd15;
    localparam logic [3:0]  GAP_MONTH       = 4'd10;
    localparam logic [3:0]  MONTH_JAN       = 4'd1;
    localparam logic [3:0]  MONTH_DEC       = 4'd12;
    localparam logic [4:0]  MOD_SHIFT_TOP   = 5'd21;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_CHUNK,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_MOD
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CHUNK,
        CMD_YEAR,
        CMD_MONTH,
        CMD_DAY
    } cmd_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [29:0] year;
        logic        era_ad;
        logic        saturated;
        logic        jan_first;
        logic        gap_year;
        logic        gap_month;
        logic        sat_year;
        logic        chunk_ok;
        logic [29:0] chunk_len;
        logic [8:0]  year_len;
        logic [4:0]  month_len;
    } cal_status_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] d;
        case (month)
            4'd2:    d = leap ? 5'd29 : 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

FILE: src/jgda_calendar.sv
// ----------------------------------------------------------------------------
// jgda_calendar
// Date registers and calendar rules; applies one step command per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jgda_calendar (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire jgda_pkg::cmd_t       cmd,
    output jgda_pkg::cal_status_t     status
);

    logic [4:0]  day_reg,   day_next;
    logic [3:0]  month_reg, month_next;
    logic [29:0] year_reg,  year_next;
    logic        era_reg,   era_next;
    logic        sat_reg,   sat_next;
    logic [8:0]  m400_reg,  m400_next;

    logic        leap;
    logic        post_gap;
    logic        gap_year;
    logic        gap_month;
    logic [4:0]  mlen;
    logic [5:0]  day_inc;

    logic [29:0] ny_year;
    logic        ny_era;
    logic        ny_sat;
    logic [8:0]  ny_m400;
    logic [8:0]  m400_plus4;

    always_comb begin
        gap_year  = era_reg && (year_reg == jgda_pkg::GAP_YEAR);
        gap_month = gap_year && (month_reg == jgda_pkg::GAP_MONTH);
        post_gap  = era_reg && (year_reg > jgda_pkg::GAP_YEAR);
        if (!era_reg) begin
            leap = (year_reg[1:0] == 2'd1);
        end else if (year_reg < jgda_pkg::GAP_YEAR) begin
            leap = (year_reg[1:0] == 2'd0);
        end else if (year_reg == jgda_pkg::GAP_YEAR) begin
            leap = 1'b0;
        end else begin
            leap = (m400_reg[1:0] == 2'd0) && (m400_reg != 9'd100)
                && (m400_reg != 9'd200) && (m400_reg != 9'd300);
        end
        mlen = jgda_pkg::month_days(month_reg, leap);

        status.day       = day_reg;
        status.month     = month_reg;
        status.year      = year_reg;
        status.era_ad    = era_reg;
        status.saturated = sat_reg;
        status.jan_first = (day_reg == 5'd1) && (month_reg == jgda_pkg::MONTH_JAN);
        status.gap_year  = gap_year;
        status.gap_month = gap_month;
        status.sat_year  = era_reg && sat_reg && (year_reg == jgda_pkg::YEAR_MAX);
        status.year_len  = leap ? jgda_pkg::DAYS_LEAP : jgda_pkg::DAYS_COMMON;
        status.month_len = mlen;
        status.chunk_len = post_gap ? jgda_pkg::DAYS_400Y : jgda_pkg::DAYS_4Y;
        if (post_gap) begin
            status.chunk_ok = (year_reg <= jgda_pkg::AD_CHUNK_LAST);
        end else if (era_reg) begin
            status.chunk_ok = (year_reg <= jgda_pkg::PRE_GAP_LAST4);
        end else begin
            status.chunk_ok = (year_reg >= jgda_pkg::BC_CHUNK_MIN);
        end
    end

    // year roll: count down in BC, cross into AD, saturate at the top
    always_comb begin
        ny_year = year_reg;
        ny_era  = era_reg;
        ny_sat  = sat_reg;
        ny_m400 = m400_reg;
        if (!era_reg) begin
            if (year_reg > 30'd1) begin
                ny_year = year_reg - 30'd1;
            end else begin
                ny_era  = 1'b1;
                ny_m400 = 9'd1;
            end
        end else if (year_reg >= jgda_pkg::YEAR_MAX) begin
            ny_year = jgda_pkg::YEAR_MAX;
            ny_sat  = 1'b1;
        end else begin
            ny_year = year_reg + 30'd1;
            ny_m400 = (m400_reg == jgda_pkg::CYCLE_LAST) ? 9'd0 : m400_reg + 9'd1;
        end
    end

    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        era_next   = era_reg;
        sat_next   = sat_reg;
        m400_next  = m400_reg;
        day_inc    = {1'b0, day_reg} + 6'd1;
        m400_plus4 = m400_reg + 9'd4;
        if (m400_plus4 >= jgda_pkg::CYCLE_LEN) begin
            m400_plus4 = m400_plus4 - jgda_pkg::CYCLE_LEN;
        end
        case (cmd)
            jgda_pkg::CMD_CHUNK: begin
                if (post_gap) begin
                    year_next = year_reg + jgda_pkg::YEARS_400;
                end else if (era_reg) begin
                    year_next = year_reg + jgda_pkg::YEARS_4;
                    m400_next = m400_plus4;
                end else begin
                    year_next = year_reg - jgda_pkg::YEARS_4;
                end
            end
            jgda_pkg::CMD_YEAR: begin
                year_next = ny_year;
                era_next  = ny_era;
                sat_next  = ny_sat;
                m400_next = ny_m400;
            end
            jgda_pkg::CMD_MONTH, jgda_pkg::CMD_DAY: begin
                if ((cmd == jgda_pkg::CMD_DAY) && gap_month
                        && (day_inc == {1'b0, jgda_pkg::GAP_SKIP_DAY})) begin
                    day_next = jgda_pkg::GAP_RESUME_DAY;
                end else if ((cmd == jgda_pkg::CMD_DAY) && (day_inc <= {1'b0, mlen})) begin
                    day_next = day_inc[4:0];
                end else begin
                    day_next = 5'd1;
                    if (month_reg == jgda_pkg::MONTH_DEC) begin
                        month_next = jgda_pkg::MONTH_JAN;
                        year_next  = ny_year;
                        era_next   = ny_era;
                        sat_next   = ny_sat;
                        m400_next  = ny_m400;
                    end else begin
                        month_next = month_reg + 4'd1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg   <= 5'd1;
            month_reg <= jgda_pkg::MONTH_JAN;
            year_reg  <= jgda_pkg::BC_START;
            era_reg   <= 1'b0;
            sat_reg   <= 1'b0;
            m400_reg  <= 9'd0;
        end else begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            era_reg   <= era_next;
            sat_reg   <= sat_next;
            m400_reg  <= m400_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/julian_gregorian_day_advance.sv
// ----------------------------------------------------------------------------
// julian_gregorian_day_advance
// Calendar date counter from 1 January 4713 BC, advanced by a day count per
// input beat. One beat in, one date beat out.
//
// Input beat (s_*): s_tdata[29:0] holds the days to advance. The block takes
// one beat at a time; s_tready stays low until that beat's date is loaded
// into the output register.
// Output beat (m_*): m_tdata carries day, month and year; m_tuser carries
// the era and the saturation flag. The result waits in the output register
// while the receiver stalls, and the next input beat is taken meanwhile.
// Each step is a trial subtract on a shared 30-bit subtractor. A date moves
// by 400-year blocks (four-year blocks before 1583), then by whole years,
// months and single days, with a remainder pass of shifted subtracts in
// the last counted year.
// Reset: the date returns to 1 January 4713 BC, overflow clears, and any
// beat in progress or waiting at the output is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "julian_gregorian_day_advance_macros.svh"

module julian_gregorian_day_advance (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [29:0] advance_days, [31:30] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [4:0] day_of_month, [8:5] month_number,
                                        // [38:9] year_number, [39] zero
    output logic [1:0]       m_tuser    // [0] era_ad, [1] overflow
);

    jgda_pkg::state_t      state_reg, state_next;
    logic [29:0]           rem_reg,   rem_next;
    logic [4:0]            sh_reg,    sh_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [39:0]           m_tdata_reg,  m_tdata_next;
    logic [1:0]            m_tuser_reg,  m_tuser_next;

    jgda_pkg::cmd_t        cmd;
    jgda_pkg::cal_status_t cal_status;

    logic [29:0]           amt;
    logic [30:0]           diff;
    logic                  fits;
    logic                  load_out;

    jgda_calendar u_calendar (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (cal_status)
    );

    // shared subtractor: remaining days minus the span of the step under test
    always_comb begin
        case (state_reg)
            jgda_pkg::ST_CHUNK: amt = cal_status.chunk_len;
            jgda_pkg::ST_YEAR:  amt = {21'd0, cal_status.year_len};
            jgda_pkg::ST_MONTH: amt = {25'd0, cal_status.month_len};
            jgda_pkg::ST_DAY:   amt = 30'd1;
            jgda_pkg::ST_MOD:   amt = {21'd0, cal_status.year_len} << sh_reg;
            default:            amt = 30'd0;
        endcase
        diff = {1'b0, rem_reg} - {1'b0, amt};
        fits = !diff[30];
    end

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        cmd        = jgda_pkg::CMD_NONE;
        load_out   = 1'b0;
        case (state_reg)
            jgda_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    rem_next   = s_tdata[29:0];
                    state_next = jgda_pkg::ST_TOP;
                end
            end
            jgda_pkg::ST_TOP: begin
                if (rem_reg == 30'd0) begin
                    if (!m_tvalid_reg || m_tready) begin
                        load_out   = 1'b1;
                        state_next = jgda_pkg::ST_IDLE;
                    end
                end else if (cal_status.jan_first && !cal_status.gap_year) begin
                    if (cal_status.sat_year) begin
                        sh_next    = jgda_pkg::MOD_SHIFT_TOP;
                        state_next = jgda_pkg::ST_MOD;
                    end else begin
                        state_next = jgda_pkg::ST_CHUNK;
                    end
                end else begin
                    state_next = jgda_pkg::ST_MONTH;
                end
            end
            jgda_pkg::ST_CHUNK: begin
                if (cal_status.chunk_ok && fits) begin
                    rem_next   = diff[29:0];
                    cmd        = jgda_pkg::CMD_CHUNK;
                    state_next = jgda_pkg::ST_TOP;
                end else begin
                    state_next = jgda_pkg::ST_YEAR;
                end
            end
            jgda_pkg::ST_YEAR: begin
                if (fits) begin
                    rem_next   = diff[29:0];
                    cmd        = jgda_pkg::CMD_YEAR;
                    state_next = jgda_pkg::ST_TOP;
                end else begin
                    state_next = jgda_pkg::ST_MONTH;
                end
            end
            jgda_pkg::ST_MONTH: begin
                if ((cal_status.day == 5'd1) && !cal_status.gap_month && fits) begin
                    rem_next   = diff[29:0];
                    cmd        = jgda_pkg::CMD_MONTH;
                    state_next = jgda_pkg::ST_TOP;
                end else begin
                    state_next = jgda_pkg::ST_DAY;
                end
            end
            jgda_pkg::ST_DAY: begin
                rem_next   = diff[29:0];
                cmd        = jgda_pkg::CMD_DAY;
                state_next = jgda_pkg::ST_TOP;
            end
            jgda_pkg::ST_MOD: begin
                // wrap the count inside the last year, one shifted subtract a cycle
                if (fits) begin
                    rem_next = diff[29:0];
                end
                if (sh_reg == 5'd0) begin
                    state_next = (rem_next == 30'd0) ? jgda_pkg::ST_TOP : jgda_pkg::ST_MONTH;
                end else begin
                    sh_next = sh_reg - 5'd1;
                end
            end
            default: begin
                state_next = jgda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {1'b0, cal_status.year, cal_status.month, cal_status.day};
            m_tuser_next  = {cal_status.saturated, cal_status.era_ad};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= jgda_pkg::ST_IDLE;
            sh_reg       <= 5'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sh_reg       <= sh_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == jgda_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `JGDA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted beat left block ready")
    `JGDA_ASSERT_NOW(a_month_range, (cal_status.month >= 4'd1) && (cal_status.month <= 4'd12), "month out of range")
    `JGDA_ASSERT_NEXT(a_overflow_sticky, cal_status.saturated, cal_status.saturated, "overflow cleared")
    `JGDA_ASSERT_NOW(a_mod_last_year, (state_reg != jgda_pkg::ST_MOD) || cal_status.sat_year, "remainder pass outside last year")

endmodule

`default_nettype wire
